### hdl/json_string_unescape_core_defines.svh
// assertion helpers shared by the unescape core modules
`ifndef JSON_STRING_UNESCAPE_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_CORE_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and small decode functions for the JSON string
// unescape core.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

   localparam int CFG_W       = 20;
   localparam int MAX_RESULTS = 4;
   localparam int RES_CNT_W   = 3;
   localparam int RES_IDX_W   = 2;
   localparam int CP_W        = 21;

   localparam logic [CFG_W-1:0] MAX_BYTES_RESET = 20'hFFFFF;
   localparam logic [CP_W-1:0]  SUPP_BASE       = 21'h10000;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_BODY  = 3'd1,
      MODE_ESC   = 3'd2,
      MODE_HEX1  = 3'd3,
      MODE_LOWBS = 3'd4,
      MODE_LOWU  = 3'd5,
      MODE_HEX2  = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE     = 4'd0,
      ERR_NO_QUOTE = 4'd1,
      ERR_TOO_LONG = 4'd2,
      ERR_CONTROL  = 4'd3,
      ERR_ESC_END  = 4'd4,
      ERR_BAD_ESC  = 4'd5,
      ERR_UNI_END  = 4'd6,
      ERR_BAD_HEX  = 4'd7,
      ERR_NO_LOW   = 4'd8,
      ERR_BAD_LOW  = 4'd9,
      ERR_LONE_LOW = 4'd10,
      ERR_UNTERM   = 4'd11
   } err_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      err_type    err;
   } rsp_entry_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]                 count;
      rsp_entry_type [MAX_RESULTS-1:0]      ent;
   } rsp_bundle_type;

   function automatic rsp_entry_type byte_entry(input logic [7:0] d);
      rsp_entry_type e;
      e.kind = KIND_BYTE;
      e.data = d;
      e.err  = ERR_NONE;
      return e;
   endfunction

   function automatic rsp_bundle_type single_bundle(input kind_type k, input logic [7:0] d,
                                                    input err_type code);
      rsp_bundle_type b;
      b            = '0;
      b.count      = RES_CNT_W'(1);
      b.ent[0].kind = k;
      b.ent[0].data = d;
      b.ent[0].err  = code;
      return b;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // {valid, byte} for the single-character escapes
   function automatic logic [8:0] escape_map(input logic [7:0] c);
      logic [8:0] r;
      r = '0;
      if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
         r = {1'b1, c};
      end else if (c == CH_LOW_B) begin
         r = {1'b1, 8'h08};
      end else if (c == CH_LOW_F) begin
         r = {1'b1, 8'h0C};
      end else if (c == CH_LOW_N) begin
         r = {1'b1, 8'h0A};
      end else if (c == CH_LOW_R) begin
         r = {1'b1, 8'h0D};
      end else if (c == CH_LOW_T) begin
         r = {1'b1, 8'h09};
      end
      return r;
   endfunction

   function automatic rsp_bundle_type utf8_encode(input logic [CP_W-1:0] cp);
      rsp_bundle_type b;
      b = '0;
      if (cp[CP_W-1:7] == '0) begin
         b.count  = RES_CNT_W'(1);
         b.ent[0] = byte_entry({1'b0, cp[6:0]});
      end else if (cp[CP_W-1:11] == '0) begin
         b.count  = RES_CNT_W'(2);
         b.ent[0] = byte_entry({3'b110, cp[10:6]});
         b.ent[1] = byte_entry({2'b10, cp[5:0]});
      end else if (cp[CP_W-1:16] == '0) begin
         b.count  = RES_CNT_W'(3);
         b.ent[0] = byte_entry({4'b1110, cp[15:12]});
         b.ent[1] = byte_entry({2'b10, cp[11:6]});
         b.ent[2] = byte_entry({2'b10, cp[5:0]});
      end else begin
         b.count  = RES_CNT_W'(4);
         b.ent[0] = byte_entry({5'b11110, cp[20:18]});
         b.ent[1] = byte_entry({2'b10, cp[17:12]});
         b.ent[2] = byte_entry({2'b10, cp[11:6]});
         b.ent[3] = byte_entry({2'b10, cp[5:0]});
      end
      return b;
   endfunction

endpackage

`default_nettype wire

### hdl/jsu_step.sv
// ----------------------------------------------------------------------------
// jsu_step
// Decode state and per-item decode logic: turns one source byte into the
// group of up to four result entries it causes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_string_unescape_core_defines.svh"

module jsu_step #(
   parameter int LENGTH_COUNT_BITS = 21
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [7:0]                    byte_in,
   input  wire logic                          input_end,
   input  wire logic [jsu_pkg::CFG_W-1:0]     max_bytes,
   output jsu_pkg::rsp_bundle_type            bundle
);

   localparam int CB    = LENGTH_COUNT_BITS;
   localparam int CMP_W = (CB > jsu_pkg::CFG_W) ? CB : jsu_pkg::CFG_W;

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [1:0]        digit_ff, digit_in;
   logic [15:0]       hex_ff, hex_in;
   logic [9:0]        high_ff, high_in;
   logic [CB-1:0]     count_ff, count_in;

   logic [CMP_W-1:0]  count_ext;
   logic [CMP_W-1:0]  max_ext;
   logic [4:0]        hd;
   logic [8:0]        esc;
   logic [15:0]       hv_full;
   logic [jsu_pkg::CP_W-1:0] pair_cp;
   logic [CB:0]       count_sum;
   logic              clear;
   jsu_pkg::rsp_bundle_type res;

   assign count_ext = CMP_W'(count_ff);
   assign max_ext   = CMP_W'(max_bytes);
   assign hd        = jsu_pkg::hex_digit(byte_in);
   assign esc       = jsu_pkg::escape_map(byte_in);
   assign hv_full   = {hex_ff[11:0], hd[3:0]};
   assign pair_cp   = jsu_pkg::SUPP_BASE + jsu_pkg::CP_W'({high_ff, hv_full[9:0]});
   assign bundle    = res;

   always_comb begin
      mode_in  = mode_ff;
      digit_in = digit_ff;
      hex_in   = hex_ff;
      high_in  = high_ff;
      res      = '0;
      clear    = 1'b0;

      if (input_end) begin
         clear = 1'b1;
         unique case (mode_ff)
            jsu_pkg::MODE_BODY: begin
               res = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_UNTERM);
            end
            jsu_pkg::MODE_ESC: begin
               res = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_ESC_END);
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
               res = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_UNI_END);
            end
            jsu_pkg::MODE_LOWBS, jsu_pkg::MODE_LOWU: begin
               res = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_NO_LOW);
            end
            default: begin
               res = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_NO_QUOTE);
            end
         endcase
      end else begin
         unique case (mode_ff)
            jsu_pkg::MODE_BODY: begin
               priority if (byte_in == jsu_pkg::CH_QUOTE) begin
                  clear = 1'b1;
                  if (count_ext > max_ext) begin
                     res = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                  jsu_pkg::ERR_TOO_LONG);
                  end else begin
                     res = jsu_pkg::single_bundle(jsu_pkg::KIND_DONE, 8'h00,
                                                  jsu_pkg::ERR_NONE);
                  end
               end else if (byte_in < jsu_pkg::CH_SPACE) begin
                  clear = 1'b1;
                  res   = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                 jsu_pkg::ERR_CONTROL);
               end else if (byte_in == jsu_pkg::CH_BSLASH) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end else if (count_ext >= max_ext) begin
                  clear = 1'b1;
                  res   = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                 jsu_pkg::ERR_TOO_LONG);
               end else begin
                  res = jsu_pkg::single_bundle(jsu_pkg::KIND_BYTE, byte_in,
                                               jsu_pkg::ERR_NONE);
               end
            end
            jsu_pkg::MODE_ESC: begin
               priority if (esc[8]) begin
                  res     = jsu_pkg::single_bundle(jsu_pkg::KIND_BYTE, esc[7:0],
                                                   jsu_pkg::ERR_NONE);
                  mode_in = jsu_pkg::MODE_BODY;
               end else if (byte_in == jsu_pkg::CH_LOW_U) begin
                  mode_in  = jsu_pkg::MODE_HEX1;
                  digit_in = 2'd0;
                  hex_in   = '0;
               end else begin
                  clear = 1'b1;
                  res   = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                 jsu_pkg::ERR_BAD_ESC);
               end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
               priority if (!hd[4]) begin
                  clear = 1'b1;
                  res   = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                 jsu_pkg::ERR_BAD_HEX);
               end else if (digit_ff != 2'd3) begin
                  hex_in   = hv_full;
                  digit_in = digit_ff + 2'd1;
               end else begin
                  // fourth digit: the quad is complete
                  hex_in   = '0;
                  digit_in = 2'd0;
                  if (mode_ff == jsu_pkg::MODE_HEX1) begin
                     priority if (hv_full[15:10] == jsu_pkg::HIGH_SURR_TAG) begin
                        high_in = hv_full[9:0];
                        mode_in = jsu_pkg::MODE_LOWBS;
                     end else if (hv_full[15:10] == jsu_pkg::LOW_SURR_TAG) begin
                        clear = 1'b1;
                        res   = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                       jsu_pkg::ERR_LONE_LOW);
                     end else begin
                        res     = jsu_pkg::utf8_encode(jsu_pkg::CP_W'(hv_full));
                        mode_in = jsu_pkg::MODE_BODY;
                     end
                  end else begin
                     if (hv_full[15:10] != jsu_pkg::LOW_SURR_TAG) begin
                        clear = 1'b1;
                        res   = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                       jsu_pkg::ERR_BAD_LOW);
                     end else begin
                        res     = jsu_pkg::utf8_encode(pair_cp);
                        mode_in = jsu_pkg::MODE_BODY;
                     end
                  end
               end
            end
            jsu_pkg::MODE_LOWBS: begin
               if (byte_in == jsu_pkg::CH_BSLASH) begin
                  mode_in = jsu_pkg::MODE_LOWU;
               end else begin
                  clear = 1'b1;
                  res   = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                 jsu_pkg::ERR_NO_LOW);
               end
            end
            jsu_pkg::MODE_LOWU: begin
               if (byte_in == jsu_pkg::CH_LOW_U) begin
                  mode_in  = jsu_pkg::MODE_HEX2;
                  digit_in = 2'd0;
                  hex_in   = '0;
               end else begin
                  clear = 1'b1;
                  res   = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                 jsu_pkg::ERR_NO_LOW);
               end
            end
            default: begin
               if (byte_in == jsu_pkg::CH_QUOTE) begin
                  mode_in  = jsu_pkg::MODE_BODY;
                  digit_in = 2'd0;
                  hex_in   = '0;
                  high_in  = '0;
               end else begin
                  clear = 1'b1;
                  res   = jsu_pkg::single_bundle(jsu_pkg::KIND_ERR, 8'h00,
                                                 jsu_pkg::ERR_NO_QUOTE);
               end
            end
         endcase
      end

      // decoded bytes only appear without done/error, so the count is the group size
      count_sum = {1'b0, count_ff} + (CB+1)'(res.count);
      if (count_sum[CB]) begin
         count_in = '1;
      end else begin
         count_in = count_sum[CB-1:0];
      end
      // idle entry from the opening quote starts a fresh count
      if (mode_ff != jsu_pkg::MODE_BODY && mode_ff != jsu_pkg::MODE_ESC &&
          mode_ff != jsu_pkg::MODE_HEX1 && mode_ff != jsu_pkg::MODE_HEX2 &&
          mode_ff != jsu_pkg::MODE_LOWBS && mode_ff != jsu_pkg::MODE_LOWU) begin
         count_in = '0;
      end

      if (clear) begin
         mode_in  = jsu_pkg::MODE_IDLE;
         digit_in = 2'd0;
         hex_in   = '0;
         high_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= jsu_pkg::MODE_IDLE;
         digit_ff <= 2'd0;
         hex_ff   <= '0;
         high_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         digit_ff <= digit_in;
         hex_ff   <= hex_in;
         high_ff  <= high_in;
         count_ff <= count_in;
      end
   end

   `JSU_ASSERT_SAME(a_end_gives_error, clock, reset, accept && input_end, res.count == 3'd1 && res.ent[0].kind == jsu_pkg::KIND_ERR, "end of input must give one error")
   `JSU_ASSERT_NEXT(a_final_goes_idle, clock, reset, accept && res.count != 3'd0 && res.ent[0].kind != jsu_pkg::KIND_BYTE, mode_ff == jsu_pkg::MODE_IDLE, "done or error must return to idle")
   `JSU_ASSERT_SAME(a_idle_is_clean, clock, reset, mode_ff == jsu_pkg::MODE_IDLE, digit_ff == 2'd0 && hex_ff == 16'd0 && count_ff == '0, "idle state must be cleared")

endmodule

`default_nettype wire

### hdl/jsu_rsp_buf.sv
// ----------------------------------------------------------------------------
// jsu_rsp_buf
// Result register: holds the group of result entries caused by one item and
// hands them out one per cycle on the result channel while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_string_unescape_core_defines.svh"

module jsu_rsp_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire jsu_pkg::rsp_bundle_type bundle,
   output logic                         can_take,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [7:0]                   rsp_data_byte,
   output logic [3:0]                   rsp_error_code,
   output logic                         rsp_last
);

   jsu_pkg::rsp_entry_type                ent_ff [jsu_pkg::MAX_RESULTS];
   logic [jsu_pkg::RES_CNT_W-1:0]         left_ff, left_in;
   logic [jsu_pkg::RES_IDX_W-1:0]         rd_ff, rd_in;
   logic                                  pop;
   jsu_pkg::rsp_entry_type                head;

   assign pop       = (left_ff != '0) && !rsp_stall;
   // room for a new group when empty or the last waiting entry leaves this cycle
   assign can_take  = (left_ff == '0) || ((left_ff == jsu_pkg::RES_CNT_W'(1)) && !rsp_stall);
   assign rsp_valid = (left_ff != '0);

   assign head           = ent_ff[rd_ff];
   assign rsp_kind       = 2'(head.kind);
   assign rsp_data_byte  = head.data;
   assign rsp_error_code = 4'(head.err);
   assign rsp_last       = (left_ff == jsu_pkg::RES_CNT_W'(1));

   always_comb begin
      left_in = left_ff;
      rd_in   = rd_ff;
      if (push) begin
         left_in = bundle.count;
         rd_in   = '0;
      end else if (pop) begin
         left_in = left_ff - jsu_pkg::RES_CNT_W'(1);
         rd_in   = rd_ff + jsu_pkg::RES_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         rd_ff   <= '0;
      end else begin
         left_ff <= left_in;
         rd_ff   <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
            ent_ff[i] <= bundle.ent[i];
         end
      end
   end

   `JSU_ASSERT_SAME(a_push_has_room, clock, reset, push,
                    left_ff == 3'd0 || (left_ff == 3'd1 && !rsp_stall),
                    "group written over waiting entries")
   `JSU_ASSERT_SAME(a_left_bounded, clock, reset, 1'b1, left_ff <= 3'd4,
                    "too many entries waiting")
   `JSU_ASSERT_NEXT(a_drain_to_empty, clock, reset, pop && !push && left_ff == 3'd1,
                    left_ff == 3'd0, "buffer must empty after last entry")

endmodule

`default_nettype wire

### hdl/json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Streaming decoder for one JSON string literal into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one source byte per item, opening quote first; req_input_end
//   marks the end of the source (the byte is then ignored). rsp_* carries
//   result items: a decoded byte, string complete, or an error with its code.
//   rsp_last marks the final result caused by one source byte. An error or the
//   closing quote returns the decoder to idle, waiting for an opening quote.
//   csr_wr_en/csr_wr_data set the length limit in decoded bytes; write it only
//   while the block is idle.
// Timing:
//   A source byte is decoded in the cycle it is accepted; its first result is
//   valid the next cycle. Most bytes give zero or one result, so one byte per
//   cycle is sustained while rsp_stall is low. A \u escape ending a code point
//   gives one to four UTF-8 bytes, which drain one per cycle, unless stalled,
//   from the result register; req_stall is high until the last is being taken.
// Reset:
//   Synchronous; clears the decode state and the result register and sets the
//   limit to its maximum. While rsp_stall is high the waiting result holds and
//   a new byte is taken only if the result register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_core #(
   parameter int LENGTH_COUNT_BITS = 21
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_byte_in,
   input  wire logic                        req_input_end,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic [7:0]                       rsp_data_byte,
   output logic [3:0]                       rsp_error_code,
   output logic                             rsp_last,
   input  wire logic                        csr_wr_en,
   input  wire logic [jsu_pkg::CFG_W-1:0]   csr_wr_data
);

   logic [jsu_pkg::CFG_W-1:0] max_bytes_ff;
   logic                      can_take;
   logic                      accept;
   logic                      push;
   jsu_pkg::rsp_bundle_type   bundle;

   assign req_stall = !can_take;
   assign accept    = req_valid && can_take;
   assign push      = accept && (bundle.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= jsu_pkg::MAX_BYTES_RESET;
      end else if (csr_wr_en) begin
         max_bytes_ff <= csr_wr_data;
      end
   end

   jsu_step #(
      .LENGTH_COUNT_BITS(LENGTH_COUNT_BITS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .byte_in   (req_byte_in),
      .input_end (req_input_end),
      .max_bytes (max_bytes_ff),
      .bundle    (bundle)
   );

   jsu_rsp_buf u_rsp_buf (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .bundle         (bundle),
      .can_take       (can_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

### verif/tb_json_string_unescape_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_core
// Streams JSON string literals into the unescape core and checks every result
// item. Most literals are well formed with random content, the rest are
// broken or noise. The length limit is moved between phases while the core is
// idle. Both channels idle at random. A decode model kept in the bench gives
// the expected result items, which are compared in order at the result port.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_core;

   localparam int COUNT_W = 21;

   typedef struct {
      logic [7:0] ch;
      logic       at_end;
   } src_item_type;

   typedef struct {
      jsu_pkg::kind_type kind;
      logic [7:0]        data;
      jsu_pkg::err_type  err;
      logic              last;
   } decoded_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_byte_in = '0;
   logic                      req_input_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_kind;
   logic [7:0]                rsp_data_byte;
   logic [3:0]                rsp_error_code;
   logic                      rsp_last;
   logic                      csr_wr_en = 1'b0;
   logic [jsu_pkg::CFG_W-1:0] csr_wr_data = '0;
   logic                      steady = 1'b0;

   src_item_type source_items[$];
   decoded_type  awaited_results[$];
   decoded_type  step_results[$];
   src_item_type in_flight;
   int           queued = 0;
   int           mismatches = 0;
   int           fault_sel = 0;

   // decode model state
   jsu_pkg::mode_type         dec_mode;
   logic [1:0]                dec_digits;
   logic [15:0]               dec_quad;
   logic [9:0]                dec_high;
   logic [COUNT_W-1:0]        dec_count;
   logic [jsu_pkg::CFG_W-1:0] dec_limit;

   json_string_unescape_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_in    (req_byte_in),
      .req_input_end  (req_input_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [4:0] nibble_of(input logic [7:0] b);
      if (b >= "0" && b <= "9") begin
         return {1'b1, 4'(b - "0")};
      end else if (b >= "a" && b <= "f") begin
         return {1'b1, 4'(b - "a" + 8'd10)};
      end else if (b >= "A" && b <= "F") begin
         return {1'b1, 4'(b - "A" + 8'd10)};
      end
      return '0;
   endfunction

   function automatic logic [8:0] escape_target(input logic [7:0] b);
      case (b)
         jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: return {1'b1, b};
         jsu_pkg::CH_LOW_B: return {1'b1, 8'h08};
         jsu_pkg::CH_LOW_F: return {1'b1, 8'h0C};
         jsu_pkg::CH_LOW_N: return {1'b1, 8'h0A};
         jsu_pkg::CH_LOW_R: return {1'b1, 8'h0D};
         jsu_pkg::CH_LOW_T: return {1'b1, 8'h09};
         default: return '0;
      endcase
   endfunction

   function automatic void go_idle();
      dec_mode   = jsu_pkg::MODE_IDLE;
      dec_digits = '0;
      dec_quad   = '0;
      dec_high   = '0;
      dec_count  = '0;
   endfunction

   function automatic void put_result(input jsu_pkg::kind_type k, input logic [7:0] d,
                                      input jsu_pkg::err_type e);
      decoded_type r;
      r.kind = k;
      r.data = d;
      r.err  = e;
      r.last = 1'b0;
      step_results = {step_results, r};
   endfunction

   function automatic void fail_with(input jsu_pkg::err_type e);
      put_result(jsu_pkg::KIND_ERR, 8'h00, e);
      go_idle();
   endfunction

   function automatic void add_count(input int n);
      for (int i = 0; i < n; i++) begin
         if (dec_count != '1) begin
            dec_count++;
         end
      end
   endfunction

   function automatic void put_utf8(input logic [20:0] cp);
      int n0;
      n0 = step_results.size();
      if (cp < 21'h80) begin
         put_result(jsu_pkg::KIND_BYTE, cp[7:0], jsu_pkg::ERR_NONE);
      end else if (cp < 21'h800) begin
         put_result(jsu_pkg::KIND_BYTE, 8'hC0 | 8'(cp >> 6), jsu_pkg::ERR_NONE);
         put_result(jsu_pkg::KIND_BYTE, 8'h80 | 8'(cp & 21'h3F), jsu_pkg::ERR_NONE);
      end else if (cp < 21'h10000) begin
         put_result(jsu_pkg::KIND_BYTE, 8'hE0 | 8'(cp >> 12), jsu_pkg::ERR_NONE);
         put_result(jsu_pkg::KIND_BYTE, 8'h80 | 8'((cp >> 6) & 21'h3F), jsu_pkg::ERR_NONE);
         put_result(jsu_pkg::KIND_BYTE, 8'h80 | 8'(cp & 21'h3F), jsu_pkg::ERR_NONE);
      end else begin
         put_result(jsu_pkg::KIND_BYTE, 8'hF0 | 8'((cp >> 18) & 21'h07), jsu_pkg::ERR_NONE);
         put_result(jsu_pkg::KIND_BYTE, 8'h80 | 8'((cp >> 12) & 21'h3F), jsu_pkg::ERR_NONE);
         put_result(jsu_pkg::KIND_BYTE, 8'h80 | 8'((cp >> 6) & 21'h3F), jsu_pkg::ERR_NONE);
         put_result(jsu_pkg::KIND_BYTE, 8'h80 | 8'(cp & 21'h3F), jsu_pkg::ERR_NONE);
      end
      add_count(step_results.size() - n0);
   endfunction

   // advances the model by one source byte and queues the results it causes
   function automatic void decode_byte(input logic [7:0] b, input logic at_end);
      logic [4:0] hx;
      logic [8:0] esc;
      step_results.delete();
      if (at_end) begin
         case (dec_mode)
            jsu_pkg::MODE_BODY: fail_with(jsu_pkg::ERR_UNTERM);
            jsu_pkg::MODE_ESC: fail_with(jsu_pkg::ERR_ESC_END);
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: fail_with(jsu_pkg::ERR_UNI_END);
            jsu_pkg::MODE_LOWBS, jsu_pkg::MODE_LOWU: fail_with(jsu_pkg::ERR_NO_LOW);
            default: fail_with(jsu_pkg::ERR_NO_QUOTE);
         endcase
      end else begin
         case (dec_mode)
            jsu_pkg::MODE_BODY: begin
               if (b == jsu_pkg::CH_QUOTE) begin
                  if (dec_count > dec_limit) begin
                     fail_with(jsu_pkg::ERR_TOO_LONG);
                  end else begin
                     put_result(jsu_pkg::KIND_DONE, 8'h00, jsu_pkg::ERR_NONE);
                     go_idle();
                  end
               end else if (b < jsu_pkg::CH_SPACE) begin
                  fail_with(jsu_pkg::ERR_CONTROL);
               end else if (b == jsu_pkg::CH_BSLASH) begin
                  dec_mode = jsu_pkg::MODE_ESC;
               end else if (dec_count + 1 > dec_limit) begin
                  // a plain byte over the limit ends the literal with a too-long error
                  fail_with(jsu_pkg::ERR_TOO_LONG);
               end else begin
                  put_result(jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_NONE);
                  add_count(1);
               end
            end
            jsu_pkg::MODE_ESC: begin
               esc = escape_target(b);
               if (esc[8]) begin
                  put_result(jsu_pkg::KIND_BYTE, esc[7:0], jsu_pkg::ERR_NONE);
                  add_count(1);
                  dec_mode = jsu_pkg::MODE_BODY;
               end else if (b == jsu_pkg::CH_LOW_U) begin
                  dec_mode   = jsu_pkg::MODE_HEX1;
                  dec_digits = '0;
                  dec_quad   = '0;
               end else begin
                  fail_with(jsu_pkg::ERR_BAD_ESC);
               end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
               hx = nibble_of(b);
               if (!hx[4]) begin
                  fail_with(jsu_pkg::ERR_BAD_HEX);
               end else begin
                  dec_quad = {dec_quad[11:0], hx[3:0]};
                  if (dec_digits != 2'd3) begin
                     dec_digits++;
                  end else begin
                     dec_digits = '0;
                     if (dec_mode == jsu_pkg::MODE_HEX1) begin
                        if (dec_quad >= 16'hD800 && dec_quad <= 16'hDBFF) begin
                           dec_high = dec_quad[9:0];
                           dec_mode = jsu_pkg::MODE_LOWBS;
                        end else if (dec_quad >= 16'hDC00 && dec_quad <= 16'hDFFF) begin
                           fail_with(jsu_pkg::ERR_LONE_LOW);
                        end else begin
                           put_utf8({5'd0, dec_quad});
                           dec_mode = jsu_pkg::MODE_BODY;
                        end
                     end else if (dec_quad < 16'hDC00 || dec_quad > 16'hDFFF) begin
                        fail_with(jsu_pkg::ERR_BAD_LOW);
                     end else begin
                        put_utf8(21'h10000 + {1'b0, dec_high, dec_quad[9:0]});
                        dec_mode = jsu_pkg::MODE_BODY;
                     end
                     dec_quad = '0;
                  end
               end
            end
            jsu_pkg::MODE_LOWBS: begin
               if (b == jsu_pkg::CH_BSLASH) begin
                  dec_mode = jsu_pkg::MODE_LOWU;
               end else begin
                  fail_with(jsu_pkg::ERR_NO_LOW);
               end
            end
            jsu_pkg::MODE_LOWU: begin
               if (b == jsu_pkg::CH_LOW_U) begin
                  dec_mode   = jsu_pkg::MODE_HEX2;
                  dec_digits = '0;
                  dec_quad   = '0;
               end else begin
                  fail_with(jsu_pkg::ERR_NO_LOW);
               end
            end
            default: begin
               if (b == jsu_pkg::CH_QUOTE) begin
                  go_idle();
                  dec_mode = jsu_pkg::MODE_BODY;
               end else begin
                  fail_with(jsu_pkg::ERR_NO_QUOTE);
               end
            end
         endcase
      end
      if (step_results.size() > 0) begin
         step_results[step_results.size() - 1].last = 1'b1;
      end
      awaited_results = {awaited_results, step_results};
   endfunction

   // ------------------------------------------------------------- stimulus

   function automatic void add_src(input logic [7:0] ch, input logic at_end = 1'b0);
      src_item_type it;
      it.ch     = ch;
      it.at_end = at_end;
      source_items = {source_items, it};
      queued++;
   endfunction

   // leading n hex digits of v, letters in either case
   function automatic void add_hex(input logic [15:0] v, input int n);
      logic [3:0] nib;
      for (int i = 3; i > 3 - n; i--) begin
         nib = v[4*i +: 4];
         if (nib < 4'd10) begin
            add_src("0" + 8'(nib));
         end else begin
            add_src(($urandom_range(1) ? "A" : "a") + 8'(nib) - 8'd10);
         end
      end
   endfunction

   function automatic void add_u_quad(input logic [15:0] v);
      add_src(jsu_pkg::CH_BSLASH);
      add_src(jsu_pkg::CH_LOW_U);
      add_hex(v, 4);
   endfunction

   function automatic logic [15:0] rand_high();
      return 16'hD800 + 16'($urandom_range(16'h3FF));
   endfunction

   function automatic logic [7:0] non_hex();
      logic [7:0] b;
      logic [4:0] hx;
      do begin
         b  = 8'($urandom);
         hx = nibble_of(b);
      end while (hx[4]);
      return b;
   endfunction

   function automatic void add_token();
      logic [7:0] b;
      logic [7:0] simple[8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                                jsu_pkg::CH_LOW_B, jsu_pkg::CH_LOW_F, jsu_pkg::CH_LOW_N,
                                jsu_pkg::CH_LOW_R, jsu_pkg::CH_LOW_T};
      logic [15:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            do b = 8'($urandom_range(8'h20, 8'hFF));
            while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
            add_src(b);
         end
         4, 5: begin
            add_src(jsu_pkg::CH_BSLASH);
            add_src(simple[$urandom_range(7)]);
         end
         6: add_u_quad(16'($urandom_range(16'h7F)));
         7: add_u_quad(16'($urandom_range(16'h80, 16'h7FF)));
         8: begin
            v = $urandom_range(1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                  : 16'($urandom_range(16'hE000, 16'hFFFF));
            add_u_quad(v);
         end
         default: begin
            add_u_quad(rand_high());
            add_u_quad(16'hDC00 + 16'($urandom_range(16'h3FF)));
         end
      endcase
   endfunction

   function automatic void add_string();
      add_src(jsu_pkg::CH_QUOTE);
      repeat ($urandom_range(9) < 8 ? $urandom_range(5) : $urandom_range(6, 14)) add_token();
      add_src(jsu_pkg::CH_QUOTE);
   endfunction

   // a literal cut short by one fault, or a stray byte; the faults are taken in turn
   function automatic void add_broken();
      int sel;
      logic [7:0] b;
      logic [8:0] esc;
      logic [15:0] v;
      sel = fault_sel % 13;
      fault_sel++;
      if (sel == 12) begin
         do b = 8'($urandom);
         while (b == jsu_pkg::CH_QUOTE);
         add_src(b);
         return;
      end
      add_src(jsu_pkg::CH_QUOTE);
      repeat ($urandom_range(3)) add_token();
      case (sel)
         0: add_src(8'($urandom_range(8'h1F)));
         1: begin
            do begin
               b   = 8'($urandom);
               esc = escape_target(b);
            end while (esc[8] || b == jsu_pkg::CH_LOW_U);
            add_src(jsu_pkg::CH_BSLASH);
            add_src(b);
         end
         2, 3: begin
            if (sel == 3) begin
               add_u_quad(rand_high());
            end
            add_src(jsu_pkg::CH_BSLASH);
            add_src(jsu_pkg::CH_LOW_U);
            add_hex(16'($urandom), $urandom_range(3));
            add_src(non_hex());
         end
         4: begin
            add_u_quad(rand_high());
            do b = 8'($urandom);
            while (b == jsu_pkg::CH_BSLASH);
            add_src(b);
         end
         5: begin
            add_u_quad(rand_high());
            add_src(jsu_pkg::CH_BSLASH);
            do b = 8'($urandom);
            while (b == jsu_pkg::CH_LOW_U);
            add_src(b);
         end
         6: begin
            add_u_quad(rand_high());
            do v = 16'($urandom);
            while (v >= 16'hDC00 && v <= 16'hDFFF);
            add_u_quad(v);
         end
         7: add_u_quad(16'hDC00 + 16'($urandom_range(16'h3FF)));
         8: add_src(8'($urandom), 1'b1);
         9: begin
            add_src(jsu_pkg::CH_BSLASH);
            add_src(8'($urandom), 1'b1);
         end
         10: begin
            if ($urandom_range(1)) begin
               add_u_quad(rand_high());
            end
            add_src(jsu_pkg::CH_BSLASH);
            add_src(jsu_pkg::CH_LOW_U);
            add_hex(16'($urandom), $urandom_range(3));
            add_src(8'($urandom), 1'b1);
         end
         default: begin
            add_u_quad(rand_high());
            if ($urandom_range(1)) begin
               add_src(jsu_pkg::CH_BSLASH);
            end
            add_src(8'($urandom), 1'b1);
         end
      endcase
   endfunction

   function automatic void queue_random(input int n);
      int target;
      int pick;
      target = queued + n;
      while (queued < target) begin
         pick = $urandom_range(99);
         if (pick < 68) begin
            add_string();
         end else if (pick < 88) begin
            add_broken();
         end else begin
            add_src(8'($urandom), $urandom_range(9) < 3);
         end
      end
   endfunction

   task automatic wait_drained();
      while (source_items.size() > 0 || req_valid || awaited_results.size() > 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic set_limit(input logic [jsu_pkg::CFG_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dec_limit = v;
   endtask

   // --------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_byte_in, req_input_end);
         end
         if (!req_valid || !req_stall) begin
            if (source_items.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
               in_flight = source_items.pop_front();
               req_valid     <= 1'b1;
               req_byte_in   <= in_flight.ch;
               req_input_end <= in_flight.at_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------- monitor

   function automatic void check_result();
      decoded_type want;
      if (awaited_results.size() == 0) begin
         $error("unexpected result: kind %0d data %02h code %0d last %0b",
                rsp_kind, rsp_data_byte, rsp_error_code, rsp_last);
         mismatches++;
         return;
      end
      want = awaited_results.pop_front();
      if (rsp_kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
         mismatches++;
      end
      if (rsp_data_byte !== want.data) begin
         $error("data_byte: expected %02h, got %02h", want.data, rsp_data_byte);
         mismatches++;
      end
      if (rsp_error_code !== want.err) begin
         $error("error_code: expected %0d, got %0d", want.err, rsp_error_code);
         mismatches++;
      end
      if (rsp_last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, rsp_last);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            check_result();
         end
         rsp_stall <= !steady && ($urandom_range(99) < 36);
      end
   end

   // ------------------------------------------------------------- sequence

   initial begin
      go_idle();
      dec_limit = jsu_pkg::MAX_BYTES_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_limit(jsu_pkg::MAX_BYTES_RESET);

      // stray byte and end of input while idle
      add_src("x");
      add_src(8'hFF, 1'b1);
      // plain extremes, escaped slash, highest code point as a surrogate pair
      add_src(jsu_pkg::CH_QUOTE);
      add_src(8'hFF);
      add_src(jsu_pkg::CH_SPACE);
      add_src(jsu_pkg::CH_BSLASH);
      add_src(jsu_pkg::CH_SLASH);
      add_u_quad(16'hDBFF);
      add_u_quad(16'hDFFF);
      add_src(jsu_pkg::CH_QUOTE);
      // control byte, then end of input inside a literal
      add_src(jsu_pkg::CH_QUOTE);
      add_src(8'h1F);
      add_src(jsu_pkg::CH_QUOTE);
      add_src(8'h00, 1'b1);
      wait_drained();

      queue_random(40);
      wait_drained();
      queue_random(20);
      wait_drained();

      set_limit('0);
      queue_random(20);
      wait_drained();

      set_limit(jsu_pkg::CFG_W'(1));
      queue_random(20);
      wait_drained();

      set_limit(jsu_pkg::CFG_W'($urandom_range(2, 12)));
      queue_random(30);
      wait_drained();

      // long stretch with no idling on either side
      steady <= 1'b1;
      set_limit(jsu_pkg::CFG_W'($urandom_range(13, 20'hFFFFE)));
      queue_random(56);
      wait_drained();
      steady <= 1'b0;

      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
